[sv/nspm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nspm_pkg: shared constants and types for the note shape pixel mask
// Field widths, packing offsets, shape codes and the internal datapath
// widths that follow from them.
// ----------------------------------------------------------------------------
package nspm_pkg;

	// request fields
	localparam int CoordBits = 12;
	localparam int CodeBits  = 3;
	localparam int WBits     = 11;
	localparam int HBits     = 6;

	// slave tdata packing, lowest field first
	localparam int BoxXLo    = 0;
	localparam int BoxYLo    = BoxXLo + CoordBits;
	localparam int WidthLo   = BoxYLo + CoordBits;
	localparam int HeightLo  = WidthLo + WBits;
	localparam int PixXLo    = HeightLo + HBits;
	localparam int PixYLo    = PixXLo + CoordBits;
	localparam int InFieldW  = PixYLo + CoordBits;
	localparam int InDataW   = ((InFieldW + 7) / 8) * 8;
	localparam int OutDataW  = 8;

	// shape codes
	localparam logic [CodeBits-1:0] ShapeRect   = 3'd0;
	localparam logic [CodeBits-1:0] ShapeRhomb  = 3'd1;
	localparam logic [CodeBits-1:0] ShapeInvEll = 3'd2;
	localparam logic [CodeBits-1:0] ShapeEll    = 3'd3;

	// datapath widths
	localparam int DW   = CoordBits + 1;                             // dx, dy
	localparam int MW   = ((DW > WBits + 1) ? DW : WBits + 1) + 2;   // 2a, u, 2b, v
	localparam int MHW  = MW + HBits + 1;                            // m*h
	localparam int NWW  = MW + WBits + 1;                            // n*w
	localparam int MSQ  = 2 * (MHW - 1);
	localparam int NSQ  = 2 * (NWW - 1);
	localparam int SW   = ((MSQ > NSQ) ? MSQ : NSQ) + 1;             // ellipse sum
	localparam int RW   = WBits + HBits;                             // w*h
	localparam int RSQ  = 2 * RW;                                    // (w*h)^2
	localparam int KW   = ((SW > RSQ) ? SW : RSQ) + 3;               // band compare
	localparam int HDW  = DW + HBits + 1;                            // h*dx
	localparam int WDW  = DW + WBits + 1;                            // w*dy
	localparam int PW   = ((WDW > HDW) ? WDW : HDW) + 2;             // rhombus P, Q
	localparam int DPW  = PW + 1;
	localparam int RCW  = ((DW > WBits + 1) ? DW : WBits + 1) + 1;   // rectangle compare

	typedef logic [CodeBits-1:0] code_t;
	typedef logic signed [DW-1:0]  dw_t;
	typedef logic signed [MW-1:0]  mw_t;
	typedef logic signed [MHW-1:0] mhw_t;
	typedef logic signed [NWW-1:0] nww_t;
	typedef logic [MSQ-1:0]        msq_t;
	typedef logic [NSQ-1:0]        nsq_t;
	typedef logic [SW-1:0]         sw_t;
	typedef logic [RW-1:0]         rw_t;
	typedef logic [RSQ-1:0]        rsq_t;
	typedef logic [KW-1:0]         kw_t;
	typedef logic signed [HDW-1:0] hdw_t;
	typedef logic signed [WDW-1:0] wdw_t;
	typedef logic signed [PW-1:0]  pw_t;
	typedef logic signed [DPW-1:0] dpw_t;
	typedef logic signed [RCW-1:0] rcw_t;

endpackage

[sv/note_shape_pixel_mask_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_shape_pixel_mask_unit: pixel inside / outline test for a note shape
// Seven-stage pipeline that decides, per pixel, whether it lies inside a
// rectangle, rhombus, inverted ellipse or ellipse box and on its border.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata / tuser contents (lsb first)
//  --------+-----+------------------------------------------------------------
//  s_*     | in  | tdata: box_x, box_y, box_width, box_height, pixel_x,
//          |     |        pixel_y, zero fill to 72 bits; tuser: shape_code
//  m_*     | out | tdata: inside_res, on_outline, zero fill to 8 bits
//
// One request enters per clock while s_tready is high; each request passes
// through s1 to s7 in order and leaves from the s7 output register.
// Stages: s1 offsets, s2 first products and selects, s3 second products,
// s4 squares and rhombus decision, s5 ellipse sum, s6 scaled terms,
// s7 band compare and shape mux (this is the output register).
// A stall at m_tready backs up only as far as the first empty stage;
// s_tready drops only when all seven stages hold a request.
// arst_n clears the stage valid bits; datapath registers are not reset.
//
// Exact integer forms used (S = ellipse sum, R = (w*h)^2):
//   inverted ellipse outline 5|S-R| <= R  <=>  4R <= 5S <= 6R
//   ellipse outline          4|S-R| <= R  <=>  3R <= 4S <= 5R
// ----------------------------------------------------------------------------
module note_shape_pixel_mask_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// box_x, box_y, box_width, box_height, pixel_x, pixel_y, zero fill
	input  logic [nspm_pkg::InDataW-1:0]     s_tdata,
	// shape_code
	input  logic [nspm_pkg::CodeBits-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// inside_res, on_outline, zero fill
	output logic [nspm_pkg::OutDataW-1:0]    m_tdata
);

	// stage enables: a stage loads when empty or when its successor moves
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	assign en_s7 = !v_s7 || m_tready;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// ------------------------------------------------------------------
	// s1: unpack and form the pixel offsets inside the box
	// ------------------------------------------------------------------
	nspm_pkg::code_t               code_s1;
	logic [nspm_pkg::WBits-1:0]    w_s1;
	logic [nspm_pkg::HBits-1:0]    h_s1;
	nspm_pkg::dw_t                 dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			code_s1 <= s_tuser;
			w_s1    <= s_tdata[nspm_pkg::WidthLo +: nspm_pkg::WBits];
			h_s1    <= s_tdata[nspm_pkg::HeightLo +: nspm_pkg::HBits];
			dx_s1   <= nspm_pkg::dw_t'($signed(s_tdata[nspm_pkg::PixXLo +: nspm_pkg::CoordBits]))
				- nspm_pkg::dw_t'($signed(s_tdata[nspm_pkg::BoxXLo +: nspm_pkg::CoordBits]));
			dy_s1   <= nspm_pkg::dw_t'($signed(s_tdata[nspm_pkg::PixYLo +: nspm_pkg::CoordBits]))
				- nspm_pkg::dw_t'($signed(s_tdata[nspm_pkg::BoxYLo +: nspm_pkg::CoordBits]));
		end
	end

	// ------------------------------------------------------------------
	// s2: rectangle border, half selects, ellipse terms, rhombus products
	// ------------------------------------------------------------------
	nspm_pkg::rcw_t dx_r, dy_r, w_r, h_r;
	logic           rect_c;
	nspm_pkg::mw_t  dx2_m, dy2_m, w_m, h_m, m_c, n_c;
	logic           left_c, top_c, inv_c;

	always_comb begin
		dx_r   = nspm_pkg::rcw_t'(dx_s1);
		dy_r   = nspm_pkg::rcw_t'(dy_s1);
		w_r    = nspm_pkg::rcw_t'(w_s1);
		h_r    = nspm_pkg::rcw_t'(h_s1);
		rect_c = (dx_r == nspm_pkg::rcw_t'(0)) || (dx_r == nspm_pkg::rcw_t'(1)) ||
			(dx_r == w_r - nspm_pkg::rcw_t'(2)) || (dx_r == w_r - nspm_pkg::rcw_t'(1)) ||
			(dy_r == nspm_pkg::rcw_t'(0)) || (dy_r == nspm_pkg::rcw_t'(1)) ||
			(dy_r == h_r - nspm_pkg::rcw_t'(2)) || (dy_r == h_r - nspm_pkg::rcw_t'(1));

		dx2_m  = nspm_pkg::mw_t'(dx_s1) <<< 1;
		dy2_m  = nspm_pkg::mw_t'(dy_s1) <<< 1;
		w_m    = nspm_pkg::mw_t'(w_s1);
		h_m    = nspm_pkg::mw_t'(h_s1);
		left_c = dx2_m <= w_m;
		top_c  = dy2_m <= h_m;
		inv_c  = code_s1 == nspm_pkg::ShapeInvEll;
		// inverted ellipse: 2a, 2b (corner-relative); ellipse: u, v (center-relative)
		if (inv_c) begin
			m_c = left_c ? dx2_m : dx2_m - (w_m <<< 1);
			n_c = top_c ? dy2_m : dy2_m - (h_m <<< 1);
		end else begin
			m_c = dx2_m - w_m;
			n_c = dy2_m - h_m;
		end
	end

	nspm_pkg::code_t               code_s2;
	logic [nspm_pkg::WBits-1:0]    w_s2;
	logic [nspm_pkg::HBits-1:0]    h_s2;
	logic                          left_s2, rect_s2;
	nspm_pkg::mw_t                 m_s2, n_s2;
	nspm_pkg::hdw_t                hdx_s2;
	nspm_pkg::wdw_t                wdy_s2;
	nspm_pkg::rw_t                 hw_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			code_s2 <= code_s1;
			w_s2    <= w_s1;
			h_s2    <= h_s1;
			left_s2 <= left_c;
			rect_s2 <= rect_c;
			m_s2    <= m_c;
			n_s2    <= n_c;
			hdx_s2  <= nspm_pkg::hdw_t'(h_s1) * nspm_pkg::hdw_t'(dx_s1);
			wdy_s2  <= nspm_pkg::wdw_t'(w_s1) * nspm_pkg::wdw_t'(dy_s1);
			hw_s2   <= nspm_pkg::rw_t'(w_s1) * nspm_pkg::rw_t'(h_s1);
		end
	end

	// ------------------------------------------------------------------
	// s3: scaled ellipse terms, R, rhombus P/Q and their targets
	// ------------------------------------------------------------------
	nspm_pkg::pw_t hdx_p, wdy_p, hw_p;

	always_comb begin
		hdx_p = nspm_pkg::pw_t'(hdx_s2);
		wdy_p = nspm_pkg::pw_t'(wdy_s2);
		hw_p  = nspm_pkg::pw_t'(hw_s2);
	end

	nspm_pkg::code_t               code_s3;
	logic [nspm_pkg::WBits-1:0]    w_s3;
	logic                          left_s3, rect_s3;
	nspm_pkg::mhw_t                mh_s3;
	nspm_pkg::nww_t                nw_s3;
	nspm_pkg::rsq_t                r_s3;
	nspm_pkg::pw_t                 p_s3, q_s3, tp_s3, tq_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			code_s3 <= code_s2;
			w_s3    <= w_s2;
			left_s3 <= left_s2;
			rect_s3 <= rect_s2;
			mh_s3   <= nspm_pkg::mhw_t'(m_s2) * nspm_pkg::mhw_t'(h_s2);
			nw_s3   <= nspm_pkg::nww_t'(n_s2) * nspm_pkg::nww_t'(w_s2);
			r_s3    <= nspm_pkg::rsq_t'(hw_s2) * nspm_pkg::rsq_t'(hw_s2);
			p_s3    <= (hdx_p + wdy_p) <<< 1;
			q_s3    <= (wdy_p - hdx_p) <<< 1;
			// left half: P, Q against HW; right half: P against 3HW, Q against -HW
			tp_s3   <= left_s2 ? hw_p : (hw_p <<< 1) + hw_p;
			tq_s3   <= left_s2 ? hw_p : -hw_p;
		end
	end

	// ------------------------------------------------------------------
	// s4: squares of the ellipse terms, rhombus decision
	// ------------------------------------------------------------------
	nspm_pkg::mhw_t                  mh_abs;
	nspm_pkg::nww_t                  nw_abs;
	logic [nspm_pkg::MHW-2:0]        mh_mag;
	logic [nspm_pkg::NWW-2:0]        nw_mag;
	nspm_pkg::dpw_t                  dp, dq, w2;
	logic                            ins_rh_c, brd_rh_c;

	always_comb begin
		mh_abs   = mh_s3[nspm_pkg::MHW-1] ? -mh_s3 : mh_s3;
		nw_abs   = nw_s3[nspm_pkg::NWW-1] ? -nw_s3 : nw_s3;
		mh_mag   = mh_abs[nspm_pkg::MHW-2:0];
		nw_mag   = nw_abs[nspm_pkg::NWW-2:0];
		dp       = nspm_pkg::dpw_t'(p_s3) - nspm_pkg::dpw_t'(tp_s3);
		dq       = nspm_pkg::dpw_t'(q_s3) - nspm_pkg::dpw_t'(tq_s3);
		w2       = nspm_pkg::dpw_t'(w_s3) <<< 1;
		if (left_s3) begin
			ins_rh_c = (dp >= nspm_pkg::dpw_t'(0)) && (dq <= nspm_pkg::dpw_t'(0));
		end else begin
			ins_rh_c = (dp <= nspm_pkg::dpw_t'(0)) && (dq >= nspm_pkg::dpw_t'(0));
		end
		brd_rh_c = ((dp >= -w2) && (dp <= w2)) || ((dq >= -w2) && (dq <= w2));
	end

	nspm_pkg::code_t code_s4;
	logic            rect_s4, ins_rh_s4, brd_rh_s4;
	nspm_pkg::msq_t  mh2_s4;
	nspm_pkg::nsq_t  nw2_s4;
	nspm_pkg::rsq_t  r_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			code_s4   <= code_s3;
			rect_s4   <= rect_s3;
			ins_rh_s4 <= ins_rh_c;
			brd_rh_s4 <= brd_rh_c;
			mh2_s4    <= nspm_pkg::msq_t'(mh_mag) * nspm_pkg::msq_t'(mh_mag);
			nw2_s4    <= nspm_pkg::nsq_t'(nw_mag) * nspm_pkg::nsq_t'(nw_mag);
			r_s4      <= r_s3;
		end
	end

	// ------------------------------------------------------------------
	// s5: ellipse sum S
	// ------------------------------------------------------------------
	nspm_pkg::code_t code_s5;
	logic            rect_s5, ins_rh_s5, brd_rh_s5;
	nspm_pkg::sw_t   sum_s5;
	nspm_pkg::rsq_t  r_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			code_s5   <= code_s4;
			rect_s5   <= rect_s4;
			ins_rh_s5 <= ins_rh_s4;
			brd_rh_s5 <= brd_rh_s4;
			sum_s5    <= nspm_pkg::sw_t'(mh2_s4) + nspm_pkg::sw_t'(nw2_s4);
			r_s5      <= r_s4;
		end
	end

	// ------------------------------------------------------------------
	// s6: scaled S and band limits, interior test
	// ------------------------------------------------------------------
	nspm_pkg::kw_t sk, rk, ks_c, lo_c, hi_c;
	logic          inv5, ins_el_c;

	always_comb begin
		sk   = nspm_pkg::kw_t'(sum_s5);
		rk   = nspm_pkg::kw_t'(r_s5);
		inv5 = code_s5 == nspm_pkg::ShapeInvEll;
		if (inv5) begin
			ks_c     = (sk << 2) + sk;
			lo_c     = rk << 2;
			hi_c     = (rk << 2) + (rk << 1);
			ins_el_c = sk >= rk;
		end else begin
			ks_c     = sk << 2;
			lo_c     = (rk << 1) + rk;
			hi_c     = (rk << 2) + rk;
			ins_el_c = sk <= rk;
		end
	end

	nspm_pkg::code_t code_s6;
	logic            rect_s6, ins_rh_s6, brd_rh_s6, ins_el_s6;
	nspm_pkg::kw_t   ks_s6, lo_s6, hi_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			code_s6   <= code_s5;
			rect_s6   <= rect_s5;
			ins_rh_s6 <= ins_rh_s5;
			brd_rh_s6 <= brd_rh_s5;
			ins_el_s6 <= ins_el_c;
			ks_s6     <= ks_c;
			lo_s6     <= lo_c;
			hi_s6     <= hi_c;
		end
	end

	// ------------------------------------------------------------------
	// s7: band compare and per-shape select into the output register
	// ------------------------------------------------------------------
	logic ins_c, brd_c, brd_el;

	always_comb begin
		brd_el = (ks_s6 >= lo_s6) && (ks_s6 <= hi_s6);
		case (code_s6)
			nspm_pkg::ShapeRect: begin
				ins_c = 1'b1;
				brd_c = rect_s6;
			end
			nspm_pkg::ShapeRhomb: begin
				ins_c = ins_rh_s6;
				brd_c = brd_rh_s6;
			end
			nspm_pkg::ShapeInvEll, nspm_pkg::ShapeEll: begin
				ins_c = ins_el_s6;
				brd_c = brd_el;
			end
			default: begin
				// unshaped codes mark every pixel
				ins_c = 1'b1;
				brd_c = 1'b1;
			end
		endcase
	end

	nspm_pkg::code_t code_s7;
	logic            ins_s7, brd_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			code_s7 <= code_s6;
			ins_s7  <= ins_c;
			brd_s7  <= brd_c;
		end
	end

	assign m_tvalid = v_s7;
	assign m_tdata  = {{(nspm_pkg::OutDataW - 2){1'b0}}, brd_s7, ins_s7};

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// backpressure at the input only when the output is stalled and stages 1, 4 and 7 hold requests
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && v_s1 && v_s4))
		else $error("input stalled while pipeline has room");

	// an accepted request always lands in the first stage
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted request lost at stage 1");

	// a full stage 4 that cannot move keeps its request
	a_hold_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !en_s5) |=> v_s4)
		else $error("stalled stage 4 dropped its request");

	// rectangles are always inside
	a_rect_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && code_s7 == nspm_pkg::ShapeRect) |-> m_tdata[0])
		else $error("rectangle result not inside");

	// unshaped codes flag both bits
	a_unshaped: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && code_s7 > nspm_pkg::ShapeEll) |-> (m_tdata[1:0] == 2'b11))
		else $error("unshaped code gave a cleared flag");

endmodule
